// ----- src/c8pd_pkg.sv -----
// shared types, codes and the crc-8 step function of the packet deframer
// used by every module of the deframer, depends on nothing
`default_nettype none

package c8pd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_HEAD_CRC,
    PH_DATA,
    PH_BODY_CRC
  } ph_e;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_TEXT,
    EV_MSG_OK,
    EV_MSG_ERR,
    EV_HEAD_BAD,
    EV_READ
  } ev_e;

  typedef enum logic [1:0] {
    CFG_LIMIT,
    CFG_POLY,
    CFG_START
  } cfg_idx_e;

  localparam logic [10:0] LIMIT_RST = 11'd1024;
  localparam logic [7:0]  POLY_RST  = 8'd7;
  localparam logic [7:0]  START_RST = 8'd170;
  localparam logic [7:0]  NEWLINE   = 8'h0A;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    ev_e         ev;
    logic [7:0]  ftype;
    logic [10:0] len;
    logic        rd_ok;
  } res_t;

  typedef struct packed {
    ev_e         ev;
    logic [7:0]  ftype;
    logic [10:0] len;
    logic [7:0]  rbyte;
  } out_t;

  // msb-first crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/c8pd_buf.sv -----
// receive buffer: single-port synchronous ram, registered read data
// depends on c8pd_pkg for the request struct
`default_nettype none

module c8pd_buf
  import c8pd_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output logic [7:0]    rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr[AW-1:0]] <= req_i.wdata;
      end else begin
        rdata_q <= mem_q[req_i.addr[AW-1:0]];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/c8pd_parser.sv -----
// byte parser: config registers, frame state, crc update and buffer requests
// depends on c8pd_pkg for codes, structs and crc8_step
`default_nettype none

module c8pd_parser
  import c8pd_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        push_i,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [9:0]  read_index_i,
  output mem_req_t         mem_req_o,
  output res_t             res_o
);

  localparam logic [15:0] DEPTH16 = 16'(BUF_DEPTH);

  logic [10:0] limit_q;
  logic [7:0]  poly_q;
  logic [7:0]  start_q;

  ph_e         phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] count_q, count_d;
  logic [10:0] pos_q, pos_d;

  logic [15:0] lim;
  logic [15:0] cnt_inc;
  logic [15:0] cnt_full;
  logic [15:0] pos16;
  logic [10:0] pos_inc;
  logic [7:0]  crc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
      poly_q  <= POLY_RST;
      start_q <= START_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LIMIT: limit_q <= cfg_wdata_i;
        CFG_POLY:  poly_q  <= cfg_wdata_i[7:0];
        CFG_START: start_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      type_q  <= '0;
      crc_q   <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      crc_q   <= crc_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  // limit clamped to 1..depth
  always_comb begin
    if (limit_q == '0) begin
      lim = 16'd1;
    end else if ({5'b0, limit_q} > DEPTH16) begin
      lim = DEPTH16;
    end else begin
      lim = {5'b0, limit_q};
    end
  end

  assign cnt_inc  = count_q + 16'd1;
  assign cnt_full = {rx_byte_i, count_q[7:0]};
  assign pos16    = {5'b0, pos_q};
  assign pos_inc  = pos_q + 11'd1;
  assign crc_next = crc8_step((phase_q == PH_TYPE) ? 8'h00 : crc_q, rx_byte_i, poly_q);

  always_comb begin
    phase_d   = phase_q;
    type_d    = type_q;
    crc_d     = crc_q;
    count_d   = count_q;
    pos_d     = pos_q;
    mem_req_o = '{en: 1'b0, we: 1'b0, addr: '0, wdata: rx_byte_i};
    res_o     = '{ev: EV_NONE, ftype: '0, len: '0, rd_ok: 1'b0};

    if (push_i && op_i) begin
      res_o.ev        = EV_READ;
      res_o.rd_ok     = {6'b0, read_index_i} < DEPTH16;
      mem_req_o.en    = 1'b1;
      mem_req_o.addr  = {6'b0, read_index_i};
    end else if (push_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == start_q) begin
            phase_d = PH_TYPE;
            if (count_q != '0) begin
              res_o.ev  = EV_TEXT;
              res_o.len = count_q[10:0];
              count_d   = '0;
            end
          end else begin
            mem_req_o.en   = count_q < DEPTH16;
            mem_req_o.we   = 1'b1;
            mem_req_o.addr = count_q;
            if (cnt_inc >= lim || rx_byte_i == NEWLINE) begin
              res_o.ev  = EV_TEXT;
              res_o.len = count_q[10:0];
              count_d   = '0;
            end else begin
              count_d = cnt_inc;
            end
          end
        end
        PH_TYPE: begin
          type_d  = rx_byte_i;
          crc_d   = crc_next;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          count_d = {8'h00, rx_byte_i};
          crc_d   = crc_next;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (cnt_full > lim) begin
            res_o.ev    = EV_MSG_ERR;
            res_o.ftype = type_q;
            res_o.len   = lim[10:0];
            count_d     = '0;
            phase_d     = PH_IDLE;
          end else begin
            count_d = cnt_full;
            pos_d   = '0;
            crc_d   = crc_next;
            phase_d = PH_HEAD_CRC;
          end
        end
        PH_HEAD_CRC: begin
          if (crc_q == rx_byte_i) begin
            phase_d = PH_DATA;
          end else begin
            res_o.ev    = EV_HEAD_BAD;
            res_o.ftype = type_q;
            count_d     = '0;
            phase_d     = PH_IDLE;
          end
        end
        PH_DATA: begin
          mem_req_o.en   = pos16 < DEPTH16;
          mem_req_o.we   = 1'b1;
          mem_req_o.addr = pos16;
          crc_d          = crc_next;
          pos_d          = pos_inc;
          if ({5'b0, pos_inc} >= count_q) begin
            phase_d = PH_BODY_CRC;
          end
        end
        PH_BODY_CRC: begin
          res_o.ev    = (crc_q == rx_byte_i) ? EV_MSG_OK : EV_MSG_ERR;
          res_o.ftype = type_q;
          res_o.len   = count_q[10:0];
          count_d     = '0;
          phase_d     = PH_IDLE;
        end
        default: begin
          count_d = '0;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // payload position stays below the announced length, or is zero
  a_data_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (pos16 < count_q) || (pos_q == '0))
    else $error("payload position past frame length");

  // text fill never reaches the buffer end
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> count_q < DEPTH16)
    else $error("text count out of buffer");

endmodule

`default_nettype wire

// ----- src/c8pd_outq.sv -----
// result path: read-data stage behind the buffer and a two-entry output queue
// depends on c8pd_pkg for the result structs
`default_nettype none

module c8pd_outq
  import c8pd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire res_t       res_i,
  input  wire logic [7:0] mem_rdata_i,
  output logic            ready_o,
  output logic            valid_o,
  input  wire logic       taken_i,
  output out_t            out_o
);

  logic       s1_valid_q, s1_valid_d;
  res_t       s1_res_q;
  out_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic       s1_move;
  out_t       s1_out;

  assign pop     = (cnt_q != 2'd0) && taken_i;
  assign s1_move = s1_valid_q && ((cnt_q != 2'd2) || pop);
  assign ready_o = !(s1_valid_q && (cnt_q == 2'd2));
  assign valid_o = cnt_q != 2'd0;
  assign out_o   = ent_q[rd_ptr_q];

  assign s1_out = '{ev: s1_res_q.ev, ftype: s1_res_q.ftype, len: s1_res_q.len,
                    rbyte: s1_res_q.rd_ok ? mem_rdata_i : 8'h00};

  always_comb begin
    if (push_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    case ({s1_move, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
      if (s1_move) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      s1_res_q <= res_i;
    end
    if (s1_move) begin
      ent_q[wr_ptr_q] <= s1_out;
    end
  end

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> s1_valid_q)
    else $error("accepted request lost before result stage");

  // a blocked result stage keeps its contents
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_res_q))
    else $error("result stage overwritten while blocked");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue overflow");

endmodule

`default_nettype wire

// ----- src/crc8_packet_deframer.sv -----
// crc-8 packet deframer top level: parser, receive buffer and output queue
// path: a result is registered in the result stage, then in an output queue entry, before it is offered
// throughput: one request per cycle while s_axis_tready is high, set by the single buffer port and the parse update
// reset: parse state cleared, registers to 1024 / 7 / 170, buffer contents undefined
// depends on c8pd_pkg, c8pd_parser, c8pd_buf and c8pd_outq
`default_nettype none

module crc8_packet_deframer
  import c8pd_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [10:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // rx_byte, read_index, zero fill
  input  wire logic        s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // frame_type, length, read_byte, zero fill
  output logic [2:0]       m_axis_tuser    // event_res
);

  logic       push;
  mem_req_t   mem_req;
  res_t       res;
  logic [7:0] mem_rdata;
  out_t       out;

  assign push = s_axis_tvalid && s_axis_tready;

  c8pd_parser #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .op_i         (s_axis_tuser),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .read_index_i (s_axis_tdata[17:8]),
    .mem_req_o    (mem_req),
    .res_o        (res)
  );

  c8pd_buf #(
    .DEPTH(BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  c8pd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .mem_rdata_i (mem_rdata),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .taken_i     (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {5'b0, out.rbyte, out.len, out.ftype};
  assign m_axis_tuser = out.ev;

endmodule

`default_nettype wire
